[src/max_gap_seat_allocator_unit_macros.svh]
// assertion macros for the seat allocator
`ifndef MAX_GAP_SEAT_ALLOCATOR_UNIT_MACROS_SVH
`define MAX_GAP_SEAT_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define MGSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("seat allocator check failed");

// next-cycle implication
`define MGSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("seat allocator check failed");

`endif

[src/mgsa_pkg.sv]
package mgsa_pkg;

    localparam int MAX_SEATS = 64;
    localparam int IDX_W     = $clog2(MAX_SEATS);
    localparam int CNT_W     = $clog2(MAX_SEATS + 1);
    localparam int CFG_W     = 7;
    localparam int POS_W     = 6;

    localparam logic CMD_SEAT  = 1'b0;
    localparam logic CMD_LEAVE = 1'b1;

    typedef struct packed {
        logic             command;
        logic [POS_W-1:0] leave_position;
    } t_req;

    typedef struct packed {
        logic [POS_W-1:0] seat_position;
        logic             room_full;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINAL,
        ST_COMMIT
    } t_state;

    // clamp the configured count into 1..MAX_SEATS
    function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0) begin
            r = CNT_W'(1);
        end else if (32'(c) > MAX_SEATS) begin
            r = CNT_W'(MAX_SEATS);
        end else begin
            r = CNT_W'(c);
        end
        return r;
    endfunction

endpackage

[src/max_gap_seat_allocator_unit.sv]
// seat request: accepted in idle, then the scan state visits each slot of the row (count n),
// a final state checks the right end and a commit state registers the result, waiting there
// while an earlier result is still held; no new request is taken until the commit is done
// leave request: taken in idle with no result
// synchronous active-low reset clears the occupancy map and sets the count to the maximum
module max_gap_seat_allocator_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [mgsa_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                     i_req_valid,
    output logic                     o_req_ready,
    input  mgsa_pkg::t_req           i_req,
    output logic                     o_rsp_valid,
    input  logic                     i_rsp_ready,
    output mgsa_pkg::t_rsp           o_rsp
);

    `include "max_gap_seat_allocator_unit_macros.svh"

    mgsa_pkg::t_state r_state, n_state;

    logic [mgsa_pkg::CFG_W-1:0]  r_seat_count;
    logic [mgsa_pkg::MAX_SEATS-1:0] r_map, n_map;
    logic [mgsa_pkg::CNT_W-1:0] r_n, n_n;
    logic [mgsa_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [mgsa_pkg::IDX_W-1:0] r_prev, n_prev;
    logic                       r_any, n_any;
    logic [mgsa_pkg::IDX_W-1:0] r_best_d, n_best_d;
    logic [mgsa_pkg::IDX_W-1:0] r_best_p, n_best_p;
    logic                       r_rsp_valid, n_rsp_valid;
    mgsa_pkg::t_rsp             r_rsp, n_rsp;

    logic [mgsa_pkg::CNT_W-1:0] cur_n;
    logic                       req_fire;
    logic                       commit_fire;
    logic                       room_full;
    logic                       last_idx;
    logic [mgsa_pkg::IDX_W-1:0] gap;
    logic [mgsa_pkg::IDX_W-1:0] cand_d;
    logic [mgsa_pkg::IDX_W-1:0] cand_p;
    logic [mgsa_pkg::IDX_W-1:0] tail_d;
    logic [mgsa_pkg::IDX_W-1:0] n_last;

    assign cur_n       = mgsa_pkg::eff_count(r_seat_count);
    assign req_fire    = i_req_valid && o_req_ready;
    assign commit_fire = (r_state == mgsa_pkg::ST_COMMIT) && (!r_rsp_valid || i_rsp_ready);
    assign room_full   = (r_best_d == '0);
    assign n_last      = mgsa_pkg::IDX_W'(r_n - mgsa_pkg::CNT_W'(1));
    assign last_idx    = (r_idx == n_last);

    // distance unit for the slot scan and the right end
    assign gap    = mgsa_pkg::IDX_W'((r_idx - r_prev) >> 1);
    assign cand_d = r_any ? gap : r_idx;
    assign cand_p = r_any ? mgsa_pkg::IDX_W'(r_prev + gap) : '0;
    assign tail_d = n_last - r_prev;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mgsa_pkg::ST_IDLE: begin
                if (req_fire && (i_req.command == mgsa_pkg::CMD_SEAT)) begin
                    n_state = mgsa_pkg::ST_SCAN;
                end
            end
            mgsa_pkg::ST_SCAN: begin
                if (last_idx) begin
                    n_state = mgsa_pkg::ST_FINAL;
                end
            end
            mgsa_pkg::ST_FINAL: begin
                n_state = mgsa_pkg::ST_COMMIT;
            end
            mgsa_pkg::ST_COMMIT: begin
                if (commit_fire) begin
                    n_state = mgsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mgsa_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready = 1'b0;
        case (r_state)
            mgsa_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // datapath next values
    always_comb begin
        n_map       = r_map;
        n_n         = r_n;
        n_idx       = r_idx;
        n_prev      = r_prev;
        n_any       = r_any;
        n_best_d    = r_best_d;
        n_best_p    = r_best_p;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        case (r_state)
            mgsa_pkg::ST_IDLE: begin
                if (req_fire) begin
                    if (i_req.command == mgsa_pkg::CMD_LEAVE) begin
                        if (mgsa_pkg::CNT_W'(i_req.leave_position) < cur_n) begin
                            n_map[mgsa_pkg::IDX_W'(i_req.leave_position)] = 1'b0;
                        end
                    end else begin
                        n_n      = cur_n;
                        n_idx    = '0;
                        n_prev   = '0;
                        n_any    = 1'b0;
                        n_best_d = '0;
                        n_best_p = '0;
                    end
                end
            end
            mgsa_pkg::ST_SCAN: begin
                if (r_map[r_idx]) begin
                    if (cand_d > r_best_d) begin
                        n_best_d = cand_d;
                        n_best_p = cand_p;
                    end
                    n_prev = r_idx;
                    n_any  = 1'b1;
                end
                n_idx = r_idx + mgsa_pkg::IDX_W'(1);
            end
            mgsa_pkg::ST_FINAL: begin
                if (!r_any) begin
                    n_best_d = mgsa_pkg::IDX_W'(1);
                    n_best_p = '0;
                end else if (tail_d > r_best_d) begin
                    n_best_d = tail_d;
                    n_best_p = n_last;
                end
            end
            mgsa_pkg::ST_COMMIT: begin
                if (commit_fire) begin
                    n_rsp_valid = 1'b1;
                    if (room_full) begin
                        n_rsp.seat_position = '0;
                        n_rsp.room_full     = 1'b1;
                    end else begin
                        n_map[r_best_p]     = 1'b1;
                        n_rsp.seat_position = mgsa_pkg::POS_W'(r_best_p);
                        n_rsp.room_full     = 1'b0;
                    end
                end
            end
            default: begin
                n_rsp_valid = r_rsp_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mgsa_pkg::ST_IDLE;
            r_seat_count <= mgsa_pkg::CFG_W'(mgsa_pkg::MAX_SEATS);
            r_map        <= '0;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_map        <= n_map;
            r_rsp_valid  <= n_rsp_valid;
            if (i_cfg_we) begin
                r_seat_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_idx    <= n_idx;
        r_prev   <= n_prev;
        r_any    <= n_any;
        r_best_d <= n_best_d;
        r_best_p <= n_best_p;
        r_rsp    <= n_rsp;
    end

    `MGSA_ASSERT_NOW(a_full_pos_zero, o_rsp_valid && o_rsp.room_full, o_rsp.seat_position == '0)
    `MGSA_ASSERT_NOW(a_scan_in_range, r_state == mgsa_pkg::ST_SCAN, mgsa_pkg::CNT_W'(r_idx) < r_n)
    `MGSA_ASSERT_NOW(a_best_in_range, r_state == mgsa_pkg::ST_COMMIT, mgsa_pkg::CNT_W'(r_best_p) < r_n)
    `MGSA_ASSERT_NEXT(a_commit_sets_map, commit_fire && !room_full, r_map[$past(r_best_p)])

endmodule

[tb/max_gap_seat_allocator_unit_test.sv]
`timescale 1ns / 1ps

module max_gap_seat_allocator_unit_test;

    localparam int SETTLE_CYCLES  = 70;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_REQS     = 112;

    typedef struct {
        mgsa_pkg::t_req req;
        int             gap;
        bit             drain;
    } t_seat_job;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [mgsa_pkg::CFG_W-1:0]     i_cfg_wdata = '0;
    logic                           i_req_valid = 1'b0;
    logic                           o_req_ready;
    mgsa_pkg::t_req                 i_req       = '0;
    logic                           o_rsp_valid;
    logic                           i_rsp_ready = 1'b0;
    mgsa_pkg::t_rsp                 o_rsp;

    t_seat_job                      pending_reqs[$];
    mgsa_pkg::t_rsp                 seat_grants[$];
    logic [mgsa_pkg::MAX_SEATS-1:0] taken_map;
    logic [mgsa_pkg::CFG_W-1:0]     row_count;
    bit                             req_fire    = 1'b0;
    bit                             rsp_fire    = 1'b0;
    bit                             drv_active  = 1'b0;
    bit                             steady      = 1'b0;
    int                             rsp_stall   = 0;
    int                             mismatches  = 0;
    int                             idle_cycles = 0;

    max_gap_seat_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int active_seats();
        int n;
        if (row_count == '0) begin
            n = 1;
        end else if (int'(row_count) > mgsa_pkg::MAX_SEATS) begin
            n = mgsa_pkg::MAX_SEATS;
        end else begin
            n = int'(row_count);
        end
        return n;
    endfunction

    // widest gap wins, lowest slot on a tie
    function automatic mgsa_pkg::t_rsp grant_seat();
        int             n;
        int             last;
        int             best_d;
        int             best_p;
        int             d;
        bit             seen;
        mgsa_pkg::t_rsp r;
        n      = active_seats();
        last   = 0;
        best_d = 0;
        best_p = 0;
        seen   = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (taken_map[i]) begin
                d = seen ? (i - last) / 2 : i;
                if (d > best_d) begin
                    best_d = d;
                    best_p = seen ? last + d : 0;
                end
                last = i;
                seen = 1'b1;
            end
        end
        if (!seen) begin
            best_d = 1;
            best_p = 0;
        end else if (n - 1 - last > best_d) begin
            best_d = n - 1 - last;
            best_p = n - 1;
        end
        if (best_d == 0) begin
            r.seat_position = '0;
            r.room_full     = 1'b1;
        end else begin
            taken_map[best_p] = 1'b1;
            r.seat_position   = mgsa_pkg::POS_W'(best_p);
            r.room_full       = 1'b0;
        end
        return r;
    endfunction

    function automatic void free_seat(input logic [mgsa_pkg::POS_W-1:0] pos);
        if (int'(pos) < active_seats()) begin
            taken_map[pos] = 1'b0;
        end
    endfunction

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        mgsa_pkg::t_rsp want;
        req_fire = i_rst_n && i_req_valid && o_req_ready;
        rsp_fire = i_rst_n && o_rsp_valid && i_rsp_ready;
        if (!i_rst_n) begin
            taken_map = '0;
            row_count = mgsa_pkg::CFG_W'(mgsa_pkg::MAX_SEATS);
        end else begin
            if (i_cfg_we) begin
                row_count = i_cfg_wdata;
            end
            if (rsp_fire) begin
                if (seat_grants.size() == 0) begin
                    $error("seat grant with no request waiting");
                    mismatches++;
                end else begin
                    want = seat_grants.pop_front();
                    if (o_rsp.seat_position !== want.seat_position) begin
                        $error("seat_position: expected %0d, actual %0d",
                               want.seat_position, o_rsp.seat_position);
                        mismatches++;
                    end
                    if (o_rsp.room_full !== want.room_full) begin
                        $error("room_full: expected %0d, actual %0d",
                               want.room_full, o_rsp.room_full);
                        mismatches++;
                    end
                end
            end
            if (req_fire) begin
                if (i_req.command == mgsa_pkg::CMD_SEAT) begin
                    seat_grants.push_back(grant_seat());
                end else begin
                    free_seat(i_req.leave_position);
                end
            end
        end
        if (req_fire || rsp_fire ||
            (pending_reqs.size() == 0 && !drv_active && seat_grants.size() == 0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_seat_job job;
        if (!i_rst_n) begin
            drv_active = 1'b0;
        end else begin
            if (drv_active && req_fire) begin
                drv_active = 1'b0;
            end
            if (!drv_active && pending_reqs.size() > 0) begin
                if (!(pending_reqs[0].drain && seat_grants.size() > 0)) begin
                    if (pending_reqs[0].gap > 0) begin
                        pending_reqs[0].gap--;
                    end else begin
                        job = pending_reqs.pop_front();
                        i_req <= job.req;
                        drv_active = 1'b1;
                    end
                end
            end
        end
        i_req_valid <= drv_active;
    end

    // grant receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_stall = 0;
        end else if (rsp_fire) begin
            rsp_stall = steady ? 0 : $urandom_range(0, 8);
        end else if (rsp_stall > 0) begin
            rsp_stall--;
        end
        i_rsp_ready <= i_rst_n && (rsp_stall == 0);
    end

    task automatic add_req(input logic cmd, input int pos, input bit drain);
        t_seat_job job;
        job.req.command        = cmd;
        job.req.leave_position = mgsa_pkg::POS_W'(pos);
        job.gap                = steady ? 0 : $urandom_range(0, 8);
        job.drain              = drain;
        pending_reqs.push_back(job);
    endtask

    task automatic add_seat(input bit drain);
        add_req(mgsa_pkg::CMD_SEAT, $urandom_range(0, 63), drain);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || drv_active || seat_grants.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_count(input logic [mgsa_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int n_eff;
        int seat_pct;
        logic [mgsa_pkg::CFG_W-1:0] pick;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty row, both ends, gaps, free and repeated leaves
        repeat (4) add_seat(1'b0);
        add_req(mgsa_pkg::CMD_LEAVE, 63, 1'b0);
        add_req(mgsa_pkg::CMD_LEAVE, 63, 1'b0);
        add_seat(1'b0);
        add_req(mgsa_pkg::CMD_LEAVE, 0, 1'b0);
        add_seat(1'b1);
        add_seat(1'b0);
        wait_idle();

        // single slot: full row, leave beyond the count
        set_count(mgsa_pkg::CFG_W'(1));
        add_seat(1'b0);
        add_req(mgsa_pkg::CMD_LEAVE, 63, 1'b0);
        add_req(mgsa_pkg::CMD_LEAVE, 0, 1'b0);
        add_seat(1'b0);
        add_seat(1'b0);
        wait_idle();

        // zero count acts as one
        set_count(mgsa_pkg::CFG_W'(0));
        add_seat(1'b0);
        add_req(mgsa_pkg::CMD_LEAVE, 0, 1'b0);
        add_seat(1'b0);
        wait_idle();

        // count above the maximum, map kept across count changes
        set_count(mgsa_pkg::CFG_W'(127));
        repeat (2) add_seat(1'b0);
        wait_idle();
        set_count(mgsa_pkg::CFG_W'(2));
        repeat (2) add_seat(1'b0);

        for (int ph = 0; ph < 12; ph++) begin
            wait_idle();
            case (ph)
                0: pick = 7'd64;
                1: pick = 7'd1;
                2: pick = 7'd127;
                3: pick = 7'd0;
                4: pick = 7'd2;
                5: pick = 7'd65;
                6: pick = 7'd3;
                default: pick = mgsa_pkg::CFG_W'($urandom_range(1, 64));
            endcase
            set_count(pick);
            n_eff    = active_seats();
            steady   = ($urandom_range(0, 3) == 0);
            seat_pct = $urandom_range(40, 85);
            for (int k = 0; k < PHASE_REQS; k++) begin
                if ($urandom_range(0, 99) < seat_pct) begin
                    add_seat($urandom_range(0, 49) == 0);
                end else if ($urandom_range(0, 7) == 0) begin
                    add_req(mgsa_pkg::CMD_LEAVE, $urandom_range(0, 63), 1'b0);
                end else begin
                    add_req(mgsa_pkg::CMD_LEAVE, $urandom_range(0, n_eff - 1), 1'b0);
                end
            end
        end

        wait_idle();
        if (seat_grants.size() != 0) begin
            $error("%0d seat grants never arrived", seat_grants.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/mgsa_pkg.sv
src/max_gap_seat_allocator_unit.sv
tb/max_gap_seat_allocator_unit_test.sv
